FILE: rtl/ptfm_pkg.sv
// Shared types and codes of the page table frame manager.
// No dependencies; the rtl files that use it refer to it by scoped names.
`default_nettype none
package ptfm_pkg;

    // operation codes carried in the input tuser
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_MAP   = 3'd2;
    localparam logic [2:0] OP_UNMAP = 3'd3;
    localparam logic [2:0] OP_PUSH  = 3'd4;
    localparam logic [2:0] OP_QUERY = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ALREADY  = 3'd1;
    localparam logic [2:0] ST_NOT_MAP  = 3'd2;
    localparam logic [2:0] ST_NO_FRAME = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam int FRAME_W = 20;
    localparam int FLAGS_W = 12;

    // request fields that pass the queue next to the table indexes
    typedef struct packed {
        logic               wr;
        logic               user;
        logic [FRAME_W-1:0] frame;
        logic [2:0]         op;
    } t_req;

    // result word, status in the lowest bits
    typedef struct packed {
        logic               mapped;
        logic [FLAGS_W-1:0] flags;
        logic [FRAME_W-1:0] frame;
        logic [2:0]         status;
    } t_res;

endpackage
`default_nettype wire

FILE: rtl/ptfm_front.sv
// Front end: accepts a request word and splits the virtual page into
// directory and table index by reciprocal multiplication. Uses ptfm_pkg.
`default_nettype none
module ptfm_front #(
    parameter int DIRECTORY_ENTRIES = 64,
    parameter int TABLE_ENTRIES     = 1024,
    parameter int DW = 6,
    parameter int TW = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire ptfm_pkg::t_req       i_req,
    input  wire logic [15:0]          i_vpage,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [$bits(ptfm_pkg::t_req)+DW+TW-1:0] o_data
);
    // reciprocal constants, exact for every 16-bit dividend
    localparam int TL = $clog2(TABLE_ENTRIES);
    localparam int DL = $clog2(DIRECTORY_ENTRIES);
    localparam int TS = 16 + TL;
    localparam int DS = 16 + DL;
    localparam logic [16:0] TM =
        17'(((64'd1 << TS) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
    localparam logic [16:0] DM =
        17'(((64'd1 << DS) + 64'(DIRECTORY_ENTRIES) - 64'd1) / 64'(DIRECTORY_ENTRIES));
    localparam logic [15:0] TAB_C = 16'(TABLE_ENTRIES);
    localparam logic [15:0] DIR_C = 16'(DIRECTORY_ENTRIES);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIVT = 4'b0010,
        F_DIVD = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate        r_state, n_state;
    logic [15:0]    r_vpage, r_quo, r_qq;
    logic [TW-1:0]  r_tidx;
    ptfm_pkg::t_req r_req;
    logic [32:0]    prod_t, prod_d;
    logic [15:0]    tsub, dsub;

    // quotients by multiply and shift, remainders by multiply and subtract
    assign prod_t = {17'd0, r_vpage} * {16'd0, TM};
    assign prod_d = {17'd0, r_quo} * {16'd0, DM};
    assign tsub   = r_vpage - r_quo * TAB_C;
    assign dsub   = r_quo - r_qq * DIR_C;

    // sequence idle, divide by table size, divide by directory size, hand over
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_DIVT;
            F_DIVT: n_state = F_DIVD;
            F_DIVD: n_state = F_PUSH;
            F_PUSH: if (i_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold payload and index pipeline
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_req   <= i_req;
                r_vpage <= i_vpage;
            end
            F_DIVT: begin
                r_quo <= 16'(prod_t >> TS);
            end
            F_DIVD: begin
                r_tidx <= tsub[TW-1:0];
                r_qq   <= 16'(prod_d >> DS);
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_valid = (r_state == F_PUSH);
    assign o_data  = {dsub[DW-1:0], r_tidx, r_req};

endmodule
`default_nettype wire

FILE: rtl/ptfm_queue.sv
// Two-entry queue between front and back end.
// Generic over the word width; no package use.
`default_nettype none
module ptfm_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_fill;
    logic         wr, rd;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

FILE: rtl/ptfm_back.sv
// Back end: page entry memory, free frame stack, directory marks and the
// operation sequencer with the result register. Uses ptfm_pkg.
`default_nettype none
module ptfm_back #(
    parameter int DIRECTORY_ENTRIES = 64,
    parameter int TABLE_ENTRIES     = 1024,
    parameter int FREE_STACK_DEPTH  = 4096,
    parameter int DW = 6,
    parameter int TW = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [$bits(ptfm_pkg::t_req)+DW+TW-1:0] i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output ptfm_pkg::t_res            o_res
);
    localparam int RQW = $bits(ptfm_pkg::t_req);
    localparam int PW  = DW + TW;
    localparam int AW  = $clog2(FREE_STACK_DEPTH);
    localparam int CW  = $clog2(FREE_STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_C = CW'(FREE_STACK_DEPTH);
    localparam logic [TW-1:0] LAST_T = TW'(TABLE_ENTRIES - 1);
    localparam int FW = ptfm_pkg::FRAME_W;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_EXEC  = 3'b010,
        B_SWEEP = 3'b100
    } t_bstate;

    logic [31:0]  r_pmem [2**PW];
    logic [FW-1:0] r_smem [FREE_STACK_DEPTH];

    t_bstate        r_state, n_state;
    ptfm_pkg::t_req r_req;
    logic [DW-1:0]  r_dir;
    logic [TW-1:0]  r_tidx, r_sweep;
    logic [31:0]    r_ent, r_new_ent, n_new_ent;
    logic [FW-1:0]  r_s1;
    logic [CW-1:0]  r_count, n_count;
    logic [DIRECTORY_ENTRIES-1:0] r_dir_ok;
    ptfm_pkg::t_res r_res, n_res, r_out;
    logic           r_out_valid;

    ptfm_pkg::t_req q_req;
    logic [DW-1:0]  q_dir;
    logic [TW-1:0]  q_tidx;
    logic           take, table_ok, mapped, go_sweep, set_dir;
    logic           pm_we, sm_we;
    logic [PW-1:0]  pm_wa;
    logic [31:0]    pm_wd;
    logic [FW-1:0]  sm_wd;
    logic [CW-1:0]  cnt_m1, cnt_m2;
    logic [11:0]    newflags;

    assign q_req  = ptfm_pkg::t_req'(i_data[RQW-1:0]);
    assign q_tidx = i_data[RQW+TW-1:RQW];
    assign q_dir  = i_data[RQW+PW-1:RQW+TW];
    assign take   = (r_state == B_IDLE) && i_valid && !r_out_valid;
    assign o_ready = take;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign table_ok = r_dir_ok[r_dir];
    assign mapped   = table_ok && r_ent[0];
    assign newflags = {9'd0, r_req.user, r_req.wr, 1'b1};

    // carry out the operation on the entry and stack words just read
    always_comb begin
        go_sweep  = 1'b0;
        set_dir   = 1'b0;
        pm_we     = 1'b0;
        pm_wa     = {r_dir, r_tidx};
        pm_wd     = '0;
        sm_we     = 1'b0;
        sm_wd     = '0;
        n_count   = r_count;
        n_new_ent = '0;
        n_res     = '{mapped: mapped, flags: '0, frame: '0, status: ptfm_pkg::ST_OK};
        if (r_state == B_EXEC) begin
            case (r_req.op)
                ptfm_pkg::OP_ALLOC: begin
                    if (mapped) begin
                        n_res.status = ptfm_pkg::ST_ALREADY;
                    end else if (r_count == '0 || (!table_ok && r_count == CW'(1))) begin
                        n_res.status = ptfm_pkg::ST_NO_FRAME;
                    end else if (!table_ok) begin
                        n_count   = cnt_m2;
                        set_dir   = 1'b1;
                        go_sweep  = 1'b1;
                        n_new_ent = {r_s1, newflags};
                        n_res.frame = r_s1;
                    end else begin
                        n_count = cnt_m1;
                        pm_we   = 1'b1;
                        pm_wd   = {r_s1, newflags};
                        n_res.frame = r_s1;
                    end
                end
                ptfm_pkg::OP_FREE: begin
                    if (!mapped) begin
                        n_res.status = ptfm_pkg::ST_NOT_MAP;
                    end else begin
                        pm_we = 1'b1;
                        n_res.frame = r_ent[31:12];
                        if (r_count == FULL_C) begin
                            n_res.status = ptfm_pkg::ST_FULL;
                        end else begin
                            sm_we   = 1'b1;
                            sm_wd   = r_ent[31:12];
                            n_count = r_count + CW'(1);
                        end
                    end
                end
                ptfm_pkg::OP_MAP: begin
                    if (mapped) begin
                        n_res.status = ptfm_pkg::ST_ALREADY;
                    end else if (!table_ok && r_count == '0) begin
                        n_res.status = ptfm_pkg::ST_NO_FRAME;
                    end else if (!table_ok) begin
                        n_count   = cnt_m1;
                        set_dir   = 1'b1;
                        go_sweep  = 1'b1;
                        n_new_ent = {r_req.frame, newflags};
                    end else begin
                        pm_we = 1'b1;
                        pm_wd = {r_req.frame, newflags};
                    end
                end
                ptfm_pkg::OP_UNMAP: begin
                    if (!mapped) n_res.status = ptfm_pkg::ST_NOT_MAP;
                    else pm_we = 1'b1;
                end
                ptfm_pkg::OP_PUSH: begin
                    if (r_count == FULL_C) begin
                        n_res.status = ptfm_pkg::ST_FULL;
                    end else begin
                        sm_we   = 1'b1;
                        sm_wd   = r_req.frame;
                        n_count = r_count + CW'(1);
                    end
                end
                ptfm_pkg::OP_QUERY: begin
                    if (!table_ok) begin
                        n_res.status = ptfm_pkg::ST_NOT_MAP;
                    end else begin
                        n_res.frame = r_ent[31:12];
                        n_res.flags = r_ent[11:0];
                        if (!r_ent[0]) n_res.status = ptfm_pkg::ST_NOT_MAP;
                    end
                end
                default: ;
            endcase
        end else if (r_state == B_SWEEP) begin
            // clear the new table, placing the new entry at its own index
            pm_we = 1'b1;
            pm_wa = {r_dir, r_sweep};
            pm_wd = (r_sweep == r_tidx) ? r_new_ent : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (take) n_state = B_EXEC;
            B_EXEC:  n_state = go_sweep ? B_SWEEP : B_IDLE;
            B_SWEEP: if (r_sweep == LAST_T) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_dir_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (set_dir) r_dir_ok[r_dir] <= 1'b1;
            if ((r_state == B_EXEC && !go_sweep) ||
                (r_state == B_SWEEP && r_sweep == LAST_T)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch request, sweep counter and result
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req  <= q_req;
            r_dir  <= q_dir;
            r_tidx <= q_tidx;
        end
        if (r_state == B_EXEC) begin
            r_sweep   <= '0;
            r_new_ent <= n_new_ent;
            r_res     <= n_res;
            if (!go_sweep) r_out <= n_res;
        end else if (r_state == B_SWEEP) begin
            r_sweep <= r_sweep + TW'(1);
            if (r_sweep == LAST_T) r_out <= r_res;
        end
    end

    // page entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (pm_we) r_pmem[pm_wa] <= pm_wd;
        if (take) r_ent <= r_pmem[{q_dir, q_tidx}];
    end

    // free frame stack, push at the count, read the top word
    always_ff @(posedge i_clk) begin
        if (sm_we) r_smem[r_count[AW-1:0]] <= sm_wd;
        if (take) r_s1 <= r_smem[cnt_m1[AW-1:0]];
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

FILE: rtl/page_table_frame_manager_unit.sv
// Top level of the page table frame manager: front end, queue, back end.
// Uses ptfm_pkg, ptfm_front, ptfm_queue and ptfm_back.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata, tuser (opcode)
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata (result)
//
// The front end steps through accept, quotient by the table size, table index
// and directory quotient, then hand-over to the queue.
// The back end reads and executes each request, clears a new table when one is
// created, one entry per cycle, and then hands the result over.
// Each end takes a new request only after it has handed over its last one.
// Reset is synchronous, active low, and clears marks, stack count and the queue.
// A stalled result holds in the output register while two requests wait in
// the queue and one in the front end.
`default_nettype none
module page_table_frame_manager_unit #(
    parameter int DIRECTORY_ENTRIES = 64,
    parameter int TABLE_ENTRIES     = 1024,
    parameter int FREE_STACK_DEPTH  = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] virtual_page, [35:16] frame_number, [36] user_access,
    // [37] write_access, [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    // [2:0] opcode
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [22:3] entry_frame, [34:23] entry_flags, [35] is_mapped,
    // [39:36] zero
    output logic [39:0]      m_axis_tdata
);
    localparam int DW = (DIRECTORY_ENTRIES > 1) ? $clog2(DIRECTORY_ENTRIES) : 1;
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int QW = $bits(ptfm_pkg::t_req) + DW + TW;

    ptfm_pkg::t_req req;
    ptfm_pkg::t_res res;
    logic           f_valid, f_ready, b_valid, b_ready;
    logic [QW-1:0]  f_data, b_data;

    assign req = '{wr: s_axis_tdata[37], user: s_axis_tdata[36],
                   frame: s_axis_tdata[35:16], op: s_axis_tuser};

    ptfm_front #(
        .DIRECTORY_ENTRIES(DIRECTORY_ENTRIES), .TABLE_ENTRIES(TABLE_ENTRIES),
        .DW(DW), .TW(TW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req(req), .i_vpage(s_axis_tdata[15:0]),
        .o_valid(f_valid), .i_ready(f_ready), .o_data(f_data)
    );

    ptfm_queue #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_data),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_data)
    );

    ptfm_back #(
        .DIRECTORY_ENTRIES(DIRECTORY_ENTRIES), .TABLE_ENTRIES(TABLE_ENTRIES),
        .FREE_STACK_DEPTH(FREE_STACK_DEPTH), .DW(DW), .TW(TW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_data(b_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {4'd0, res};

endmodule
`default_nettype wire

FILE: rtl/ptfm_checker.sv
// Port-level checks of the page table frame manager, bound to the top level.
// Depends on page_table_frame_manager_unit port names only.
`default_nettype none
module ptfm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // drop output valid after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a present flag in the result means the page was mapped
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[35])
        else $error("present entry reported as unmapped");

    // already-mapped status only for mapped pages
    a_already: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == 3'd1 |-> m_axis_tdata[35])
        else $error("already mapped status on unmapped page");

endmodule

bind page_table_frame_manager_unit ptfm_checker u_ptfm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
